### rtl/acp_pkg.sv
// Package with shared types, codes and message patterns of the ACK and code line parser.
`timescale 1ns / 1ps

package acp_pkg;

  // Command codes carried with each input item.
  typedef enum logic [1:0] {
    CMD_RX_BYTE      = 2'd0,
    CMD_CLR_OTP_ACK  = 2'd1,
    CMD_CLR_LOCK_ACK = 2'd2,
    CMD_CLR_CODE     = 2'd3
  } acp_cmd_e;

  localparam int unsigned CODE_FIELD_W = 48;

  typedef struct packed {
    acp_cmd_e    cmd;
    logic [7:0]  rx_byte;
  } acp_in_t;

  typedef struct packed {
    logic                    otp_ack_seen;
    logic                    lockdown_ack_seen;
    logic                    code_ready;
    logic [CODE_FIELD_W-1:0] code_chars;
    logic                    line_finished;
  } acp_out_t;

  // Match results of one line, produced by the line tracker.
  typedef struct packed {
    logic line_done;
    logic otp_ack_hit;
    logic lock_ack_hit;
    logic code_hit;
  } acp_match_t;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam int unsigned ACK_OTP_LEN  = 12;
  localparam int unsigned ACK_LOCK_LEN = 17;
  localparam int unsigned CODE_PRE_LEN = 4;

  localparam logic [8*ACK_OTP_LEN-1:0]  ACK_OTP_PAT  = {"ACK_", "OTP_SENT"};
  localparam logic [8*ACK_LOCK_LEN-1:0] ACK_LOCK_PAT = {"ACK_", "LOCKDOWN_SENT"};
  localparam logic [8*CODE_PRE_LEN-1:0] CODE_PRE_PAT = "OTP:";

  // Character at position idx of a pattern of plen characters, first character
  // in the highest byte in use.
  function automatic logic [7:0] pat_char(logic [8*ACK_LOCK_LEN-1:0] pat,
                                          int unsigned plen,
                                          logic [7:0] idx);
    logic [8*ACK_LOCK_LEN-1:0] sh;
    sh = pat >> (8 * (plen - 1 - int'(idx)));
    return sh[7:0];
  endfunction

endpackage

### rtl/acp_line_tracker.sv
// Per-byte line tracker: length, content length, pattern matches and code capture.
`timescale 1ns / 1ps

module acp_line_tracker #(
  parameter int unsigned LINE_CAPACITY = 64,
  parameter int unsigned CODE_LENGTH   = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 byte_en_i,
  input  logic [7:0]                           byte_i,
  output acp_pkg::acp_match_t                  match_o,
  output logic [acp_pkg::CODE_FIELD_W-1:0]     code_o
);

  localparam int unsigned CntW       = $clog2(LINE_CAPACITY);
  localparam int unsigned StoreDepth = LINE_CAPACITY - 1;
  localparam int unsigned CodeW      = 8 * CODE_LENGTH;
  localparam int unsigned ExtW       = (CodeW > acp_pkg::CODE_FIELD_W) ? CodeW
                                                                       : acp_pkg::CODE_FIELD_W;

  logic [CntW-1:0]  len_q, len_d;
  logic [CntW-1:0]  clen_q, clen_d;
  logic             zero_q, zero_d;
  logic             ack_ok_q, ack_ok_d;
  logic             lock_ok_q, lock_ok_d;
  logic             pre_ok_q, pre_ok_d;
  logic [CodeW-1:0] buf_q, buf_d;

  logic             is_eol;
  logic             store;
  logic             grow;
  logic [7:0]       cidx;
  logic [ExtW-1:0]  buf_ext;

  assign is_eol = (byte_i == acp_pkg::CHAR_LF) || (byte_i == acp_pkg::CHAR_CR);
  assign store  = byte_en_i && !is_eol && (len_q < CntW'(StoreDepth));
  assign grow   = store && !zero_q && (byte_i != 8'd0);
  assign cidx   = 8'(clen_q);

  always_comb begin
    match_o.line_done    = byte_en_i && is_eol && (len_q != '0);
    match_o.otp_ack_hit  = match_o.line_done && ack_ok_q &&
                           (clen_q == CntW'(acp_pkg::ACK_OTP_LEN));
    match_o.lock_ack_hit = match_o.line_done && lock_ok_q && !match_o.otp_ack_hit &&
                           (clen_q == CntW'(acp_pkg::ACK_LOCK_LEN));
    match_o.code_hit     = match_o.line_done && pre_ok_q && !match_o.otp_ack_hit &&
                           !match_o.lock_ack_hit &&
                           (clen_q >= CntW'(acp_pkg::CODE_PRE_LEN));
  end

  assign buf_ext = ExtW'(buf_q);
  assign code_o  = buf_ext[acp_pkg::CODE_FIELD_W-1:0];

  always_comb begin
    len_d     = len_q;
    clen_d    = clen_q;
    zero_d    = zero_q;
    ack_ok_d  = ack_ok_q;
    lock_ok_d = lock_ok_q;
    pre_ok_d  = pre_ok_q;
    buf_d     = buf_q;
    if (match_o.line_done) begin
      len_d     = '0;
      clen_d    = '0;
      zero_d    = 1'b0;
      ack_ok_d  = 1'b1;
      lock_ok_d = 1'b1;
      pre_ok_d  = 1'b1;
      buf_d     = '0;
    end else if (store) begin
      len_d  = len_q + CntW'(1);
      zero_d = zero_q || (byte_i == 8'd0);
      if (grow) begin
        clen_d    = clen_q + CntW'(1);
        ack_ok_d  = ack_ok_q && (clen_q < CntW'(acp_pkg::ACK_OTP_LEN)) &&
                    (byte_i == acp_pkg::pat_char((8*acp_pkg::ACK_LOCK_LEN)'(acp_pkg::ACK_OTP_PAT),
                                                 acp_pkg::ACK_OTP_LEN, cidx));
        lock_ok_d = lock_ok_q && (clen_q < CntW'(acp_pkg::ACK_LOCK_LEN)) &&
                    (byte_i == acp_pkg::pat_char(acp_pkg::ACK_LOCK_PAT,
                                                 acp_pkg::ACK_LOCK_LEN, cidx));
        pre_ok_d  = pre_ok_q && ((clen_q >= CntW'(acp_pkg::CODE_PRE_LEN)) ||
                    (byte_i == acp_pkg::pat_char(
                                 (8*acp_pkg::ACK_LOCK_LEN)'(acp_pkg::CODE_PRE_PAT),
                                 acp_pkg::CODE_PRE_LEN, cidx)));
        // Each code lane catches the character at its own content position.
        for (int k = 0; k < int'(CODE_LENGTH); k++) begin
          if (clen_q == CntW'(int'(acp_pkg::CODE_PRE_LEN) + k)) begin
            buf_d[(int'(CODE_LENGTH) - 1 - k) * 8 +: 8] = byte_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      clen_q    <= '0;
      zero_q    <= 1'b0;
      ack_ok_q  <= 1'b1;
      lock_ok_q <= 1'b1;
      pre_ok_q  <= 1'b1;
      buf_q     <= '0;
    end else begin
      len_q     <= len_d;
      clen_q    <= clen_d;
      zero_q    <= zero_d;
      ack_ok_q  <= ack_ok_d;
      lock_ok_q <= lock_ok_d;
      pre_ok_q  <= pre_ok_d;
      buf_q     <= buf_d;
    end
  end

endmodule

### rtl/ack_and_code_line_parser.sv
// Top level of the ACK and code line parser: input register, flags and result register.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------------
//  in      | in        | in_valid_i / in_stall_o  | acp_in_t  (cmd, rx_byte)
//  out     | out       | out_valid_o / out_stall_i| acp_out_t (flags, code, finished)
//
// One item is taken every cycle unless the input is stalled; each item yields exactly one result item.
// An item waits in the input register and is evaluated as it moves
// into the result register, which then offers its result on the output.
// The line is never stored: per-byte match state in the line tracker decides
// the line's meaning the moment its LF or CR is evaluated.
// Reset clears the line state, all flags and the code to zero.
// A stall on the output holds the result register and, once the input register
// is full, stalls the input as well; no item is lost or repeated.
`timescale 1ns / 1ps

module ack_and_code_line_parser #(
  parameter int unsigned LINE_CAPACITY = 64,
  parameter int unsigned CODE_LENGTH   = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  acp_pkg::acp_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output acp_pkg::acp_out_t out_item_o
);

  // Input register stage.
  logic              s1_valid_q, s1_valid_d;
  acp_pkg::acp_in_t  s1_q;

  // Result register stage.
  logic              out_valid_q, out_valid_d;
  acp_pkg::acp_out_t res_q, res_d;

  // Sticky flags and the captured code.
  logic                               otp_q, otp_d;
  logic                               lock_q, lock_d;
  logic                               ready_q, ready_d;
  logic [acp_pkg::CODE_FIELD_W-1:0]   code_q, code_d;

  logic                               adv;
  logic                               proc;
  logic                               byte_en;
  acp_pkg::acp_match_t                match;
  logic [acp_pkg::CODE_FIELD_W-1:0]   line_code;

  // The result register can take a new item when empty or being drained.
  assign adv        = !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign byte_en    = proc && (s1_q.cmd == acp_pkg::CMD_RX_BYTE);

  acp_line_tracker #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .CODE_LENGTH   (CODE_LENGTH)
  ) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .byte_i    (s1_q.rx_byte),
    .match_o   (match),
    .code_o    (line_code)
  );

  // Flag updates for the item being evaluated.
  always_comb begin
    otp_d   = otp_q;
    lock_d  = lock_q;
    ready_d = ready_q;
    code_d  = code_q;
    if (proc) begin
      case (s1_q.cmd)
        acp_pkg::CMD_CLR_OTP_ACK: begin
          otp_d = 1'b0;
        end
        acp_pkg::CMD_CLR_LOCK_ACK: begin
          lock_d = 1'b0;
        end
        acp_pkg::CMD_CLR_CODE: begin
          ready_d = 1'b0;
          code_d  = '0;
        end
        default: begin
          if (match.otp_ack_hit) begin
            otp_d = 1'b1;
          end
          if (match.lock_ack_hit) begin
            lock_d = 1'b1;
          end
          if (match.code_hit) begin
            ready_d = 1'b1;
            code_d  = line_code;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_d.otp_ack_seen      = otp_d;
    res_d.lockdown_ack_seen = lock_d;
    res_d.code_ready        = ready_d;
    res_d.code_chars        = code_d;
    res_d.line_finished     = match.line_done;
    s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
    out_valid_d = adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      otp_q       <= 1'b0;
      lock_q      <= 1'b0;
      ready_q     <= 1'b0;
      code_q      <= '0;
      res_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      otp_q       <= otp_d;
      lock_q      <= lock_d;
      ready_q     <= ready_d;
      code_q      <= code_d;
      if (proc) begin
        res_q <= res_d;
      end
    end
  end

  // The input payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_item_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  // A flag can only rise in a result whose item ended a line.
  a_otp_rise_on_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_q.otp_ack_seen) |-> res_q.line_finished)
    else $error("OTP acknowledge flag rose without a finished line");

  a_lock_rise_on_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_q.lockdown_ack_seen) |-> res_q.line_finished)
    else $error("Lockdown acknowledge flag rose without a finished line");

  // Clearing the code zeroes it, so a code that is not ready reads as zero.
  a_code_zero_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_q |-> (code_q == '0))
    else $error("Code holds characters while code_ready is low");

  // A finished line matches at most one kind of message.
  a_single_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({match.otp_ack_hit, match.lock_ack_hit, match.code_hit}))
    else $error("Line matched more than one message kind");

endmodule
